### hdl/wcw_pkg.sv
// constants and types shared by the wrapping counter widener
`default_nettype none
package wcw_pkg;

	localparam int NumPorts       = 5;
	localparam int RawBits        = 22;
	localparam int TotalBits      = 64;
	localparam int KindsPerDir    = 3;
	localparam int EntriesPerPort = 2 * KindsPerDir;
	localparam int NumEntries     = NumPorts * EntriesPerPort;
	localparam int IdxW           = (NumEntries > 1) ? $clog2(NumEntries) : 1;
	// wide enough for port * entries per port over all 3-bit port codes
	localparam int EntW           = $clog2(8 * EntriesPerPort);

	localparam int OpW            = 2;
	localparam int PortW          = 3;
	localparam int KindW          = 2;
	localparam int InBits         = OpW + PortW + 1 + KindW + RawBits;
	localparam int InW            = ((InBits + 7) / 8) * 8;

	typedef enum logic [OpW-1:0] {
		OpSample = 2'd0,
		OpRead   = 2'd1,
		OpClear  = 2'd2,
		OpNop    = 2'd3
	} op_t;

	typedef enum logic [KindW-1:0] {
		KindUnicast   = 2'd0,
		KindMulticast = 2'd1,
		KindBroadcast = 2'd2,
		KindNone      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FwdNone = 2'd0,
		FwdZero = 2'd1,
		FwdData = 2'd2
	} fwd_t;

endpackage
`default_nettype wire

### hdl/wrapping_counter_widener_unit.sv
// top level: widens free-running raw packet counters into 64-bit totals
//
// Input beats on the s_ group carry one operation: sample a raw counter
// reading, read a total, or clear all six counters of a port. Every input
// beat gives exactly one output beat on the m_ group: the total after the
// operation in m_tdata and the port-in-range flag in m_tuser.
// Snapshots and totals live in two simple dual-port synchronous memories, one
// entry per port, direction and kind. The entry is read at the input beat, the
// new snapshot and total are formed in the second stage and written back when
// it moves on, which also loads the output register. One beat per cycle is
// sustained while m_tready is high, since a write that hits the entry (or
// port, for a clear) read in the same cycle is forwarded.
// Each entry has a valid flag in flip-flops: reset clears all flags at once,
// so both memories read as zero straight after reset with no clearing pass,
// and a port clear drops the six flags of that port together.
// With an output beat held and m_tready low, the output register holds; an
// item in the second stage waits and s_tready is low until the beat is taken.
`default_nettype none
module wrapping_counter_widener_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// operation, port, direction, kind, raw_count; zero padded
	input  wire logic [wcw_pkg::InW-1:0] s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// total
	output logic [wcw_pkg::TotalBits-1:0] m_tdata,
	// port_valid
	output logic                        m_tuser
);
	import wcw_pkg::*;

	// input beat fields
	op_t                in_op;
	logic [PortW-1:0]   in_port;
	logic               in_dir;
	kind_t              in_kind;
	logic [RawBits-1:0] in_raw;
	logic               in_port_ok;
	logic               in_hit;
	logic [EntW-1:0]    in_ent;
	logic [IdxW-1:0]    in_idx;

	// memories and entry flags
	logic [RawBits-1:0]   snap_mem [NumEntries];
	logic [TotalBits-1:0] tot_mem  [NumEntries];
	logic [NumEntries-1:0] vld_q;

	// second stage
	logic                 s1_valid_q;
	op_t                  op_s1;
	logic [PortW-1:0]     port_s1;
	logic                 port_ok_s1;
	logic                 hit_s1;
	logic [IdxW-1:0]      idx_s1;
	logic [RawBits-1:0]   raw_s1;
	logic                 ent_vld_s1;
	logic [RawBits-1:0]   snap_rd_s1;
	logic [TotalBits-1:0] tot_rd_s1;
	fwd_t                 fwd_s1;
	logic [RawBits-1:0]   fwd_snap_s1;
	logic [TotalBits-1:0] fwd_tot_s1;

	logic [RawBits-1:0]   snap_cur;
	logic [TotalBits-1:0] tot_cur;
	logic [RawBits-1:0]   delta;
	logic [TotalBits-1:0] tot_new;
	logic [TotalBits-1:0] result;

	logic out_valid_q;
	logic [TotalBits-1:0] total_q;
	logic port_valid_q;

	logic adv;
	logic fire;
	logic load;
	logic wr_en;
	logic clr_en;
	logic [IdxW-1:0] clr_base;

	assign in_op      = op_t'(s_tdata[OpW-1:0]);
	assign in_port    = s_tdata[OpW +: PortW];
	assign in_dir     = s_tdata[OpW+PortW];
	assign in_kind    = kind_t'(s_tdata[OpW+PortW+1 +: KindW]);
	assign in_raw     = s_tdata[OpW+PortW+1+KindW +: RawBits];
	assign in_port_ok = (EntW'(in_port) < EntW'(NumPorts));
	assign in_hit     = in_port_ok && (in_kind != KindNone);
	assign in_ent     = EntW'(in_port) * EntW'(EntriesPerPort)
	                  + (in_dir ? EntW'(KindsPerDir) : EntW'(0)) + EntW'(in_kind);
	assign in_idx     = in_ent[IdxW-1:0];

	// handshake: second stage moves on when the output register is free
	assign adv      = !out_valid_q || m_tready;
	assign fire     = s1_valid_q && adv;
	assign s_tready = !s1_valid_q || adv;
	assign load     = s_tvalid && s_tready;

	assign wr_en    = fire && (op_s1 == OpSample) && hit_s1;
	assign clr_en   = fire && (op_s1 == OpClear) && port_ok_s1;
	assign clr_base = IdxW'(EntW'(port_s1) * EntW'(EntriesPerPort));

	// current entry contents, with forwarding from the previous write or clear
	always_comb begin
		case (fwd_s1)
			FwdZero: begin
				snap_cur = '0;
				tot_cur  = '0;
			end
			FwdData: begin
				snap_cur = fwd_snap_s1;
				tot_cur  = fwd_tot_s1;
			end
			default: begin
				snap_cur = ent_vld_s1 ? snap_rd_s1 : '0;
				tot_cur  = ent_vld_s1 ? tot_rd_s1 : '0;
			end
		endcase
	end

	// difference modulo 2^RawBits covers one wrap of the raw counter
	assign delta   = raw_s1 - snap_cur;
	assign tot_new = tot_cur + TotalBits'(delta);

	always_comb begin
		result = '0;
		if (hit_s1) begin
			case (op_s1)
				OpSample: result = tot_new;
				OpRead:   result = tot_cur;
				default:  result = '0;
			endcase
		end
	end

	// memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			snap_mem[idx_s1] <= raw_s1;
			tot_mem[idx_s1]  <= tot_new;
		end
		if (load) begin
			snap_rd_s1 <= snap_mem[in_idx];
			tot_rd_s1  <= tot_mem[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q[idx_s1] <= 1'b1;
			end
			if (clr_en) begin
				for (int k = 0; k < EntriesPerPort; k++) begin
					vld_q[clr_base + IdxW'(k)] <= 1'b0;
				end
			end
		end
	end

	// second stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= FwdNone;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
				if (clr_en && (in_port == port_s1)) begin
					fwd_s1 <= FwdZero;
				end else if (wr_en && in_hit && (in_idx == idx_s1)) begin
					fwd_s1 <= FwdData;
				end else begin
					fwd_s1 <= FwdNone;
				end
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// second stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			op_s1       <= in_op;
			port_s1     <= in_port;
			port_ok_s1  <= in_port_ok;
			hit_s1      <= in_hit;
			idx_s1      <= in_idx;
			raw_s1      <= in_raw;
			ent_vld_s1  <= in_hit ? vld_q[in_idx] : 1'b0;
			fwd_snap_s1 <= raw_s1;
			fwd_tot_s1  <= tot_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			total_q      <= result;
			port_valid_q <= port_ok_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = total_q;
	assign m_tuser  = port_valid_q;

endmodule
`default_nettype wire
